// ===== hw/rtl/buddy_block_allocator_assert.svh =====
// ----------------------------------------------------------------------------
// Buddy block allocator assertion macros
// Shared assertion wrappers clocked on clock; BBA_ASSERT is gated by reset.
// ----------------------------------------------------------------------------
`ifndef BUDDY_BLOCK_ALLOCATOR_ASSERT_SVH
`define BUDDY_BLOCK_ALLOCATOR_ASSERT_SVH

// Assertion that is checked only while reset is low.
`define BBA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Assertion that is checked on every clock edge, reset included.
`define BBA_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== hw/rtl/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// Buddy block allocator package
// Widths, controller states and the command bundle shared by all modules.
// ----------------------------------------------------------------------------
package bba_pkg;

   // Largest pool order and the number of per-order free slots.
   localparam int MAX_ORDER  = 12;
   localparam int NUM_SLOTS  = MAX_ORDER + 1;
   localparam int SLOT_IDX_W = $clog2(NUM_SLOTS);

   // Field widths.
   localparam int SIZE_W  = 16;
   localparam int ADDR_W  = 12;
   localparam int ORDER_W = 4;
   localparam int WANT_W  = $clog2(SIZE_W + 1);

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_RESPOND
   } bba_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;   // register the order of the request word
      logic allocate;  // search, split and load the response register
   } bba_cmd_type;

endpackage

// ===== hw/rtl/bba_ctrl.sv =====
// ----------------------------------------------------------------------------
// Buddy block allocator controller
// Sequences capture, allocation and response handshakes.
// ----------------------------------------------------------------------------
`include "buddy_block_allocator_assert.svh"

module bba_ctrl
   import bba_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output bba_cmd_type cmd
);

   bba_state_type state_ff;
   bba_state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and handshake outputs. A new word is taken in the same cycle
   // that the pending response is taken.
   always_comb begin
      state_in     = state_ff;
      req_ready    = 1'b0;
      rsp_valid    = 1'b0;
      cmd.capture  = 1'b0;
      cmd.allocate = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            cmd.allocate = 1'b1;
            state_in     = ST_RESPOND;
         end
         ST_RESPOND: begin
            rsp_valid = 1'b1;
            req_ready = rsp_ready;
            if (rsp_ready) begin
               if (req_valid) begin
                  cmd.capture = 1'b1;
                  state_in    = ST_SEARCH;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // An accepted word always moves on to allocation in the next cycle.
   `BBA_ASSERT(a_accept_to_search, (req_valid && req_ready) |=> (state_ff == ST_SEARCH), "accepted word did not reach allocation")
   // Allocation is always followed by an offered response.
   `BBA_ASSERT(a_search_to_rsp, (state_ff == ST_SEARCH) |=> rsp_valid, "allocation did not produce a response")
   // Capture and allocation never overlap.
   `BBA_ASSERT_ALWAYS(a_cmd_exclusive, !(cmd.capture && cmd.allocate), "capture and allocate issued together")

endmodule

// ===== hw/rtl/bba_datapath.sv =====
// ----------------------------------------------------------------------------
// Buddy block allocator datapath
// Pool order register, per-order free slots, order search and block split.
// ----------------------------------------------------------------------------
`include "buddy_block_allocator_assert.svh"

module bba_datapath
   import bba_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  bba_cmd_type         cmd,
   input  logic [SIZE_W-1:0]   req_request_size,
   input  logic                csr_wr_en,
   input  logic [ORDER_W-1:0]  csr_wr_data,
   output logic                rsp_granted,
   output logic [ADDR_W-1:0]   rsp_block_address
);

   logic [ORDER_W-1:0]   mem_order_ff;
   logic [NUM_SLOTS-1:0] free_valid_ff;
   logic [NUM_SLOTS-1:0] free_valid_in;
   logic [ADDR_W-1:0]    free_address_ff [NUM_SLOTS];
   logic [ADDR_W-1:0]    free_address_in [NUM_SLOTS];
   logic [WANT_W-1:0]    want_ff;
   logic [WANT_W-1:0]    want_in;
   logic                 rsp_granted_ff;
   logic [ADDR_W-1:0]    rsp_block_address_ff;
   logic [ORDER_W-1:0]   new_order;
   logic [SIZE_W-1:0]    size_m1;
   logic [NUM_SLOTS-1:0] candidates;
   logic                 alloc_found;
   logic [SLOT_IDX_W-1:0] alloc_slot;
   logic [ADDR_W-1:0]    alloc_base;

   // Saturate the written pool order to the largest supported order.
   assign new_order = (csr_wr_data > ORDER_W'(MAX_ORDER)) ? ORDER_W'(MAX_ORDER) : csr_wr_data;

   // Order of the request: bit length of size minus one, zero for sizes 0 and 1.
   assign size_m1 = req_request_size - SIZE_W'(1);
   always_comb begin
      want_in = '0;
      if (req_request_size > SIZE_W'(1)) begin
         for (int b = 0; b < SIZE_W; b++) begin
            if (size_m1[b]) begin
               want_in = WANT_W'(b + 1);
            end
         end
      end
   end

   // Smallest order at or above the request that holds a free block.
   always_comb begin
      for (int k = 0; k < NUM_SLOTS; k++) begin
         candidates[k] = free_valid_ff[k] && (WANT_W'(k) >= want_ff);
      end
      alloc_slot = '0;
      for (int k = NUM_SLOTS - 1; k >= 0; k--) begin
         if (candidates[k]) begin
            alloc_slot = SLOT_IDX_W'(k);
         end
      end
      alloc_found = (|candidates) && (want_ff <= WANT_W'(mem_order_ff));
   end

   assign alloc_base = free_address_ff[alloc_slot];

   // Slot update: take the found block and free the upper half at each order
   // between the request order and the found order.
   always_comb begin
      free_valid_in = free_valid_ff;
      for (int k = 0; k < NUM_SLOTS; k++) begin
         free_address_in[k] = free_address_ff[k];
         if (alloc_found) begin
            if (SLOT_IDX_W'(k) == alloc_slot) begin
               free_valid_in[k]   = 1'b0;
               free_address_in[k] = '0;
            end else if ((WANT_W'(k) >= want_ff) && (SLOT_IDX_W'(k) < alloc_slot)) begin
               free_valid_in[k]   = 1'b1;
               free_address_in[k] = alloc_base + (ADDR_W'(1) << k);
            end
         end
      end
   end

   // Pool state. Reset and a pool order write both leave one free block at 0.
   always_ff @(posedge clock) begin
      if (reset) begin
         mem_order_ff  <= ORDER_W'(MAX_ORDER);
         free_valid_ff <= NUM_SLOTS'(1) << MAX_ORDER;
         for (int k = 0; k < NUM_SLOTS; k++) begin
            free_address_ff[k] <= '0;
         end
      end else if (csr_wr_en) begin
         mem_order_ff  <= new_order;
         free_valid_ff <= NUM_SLOTS'(1) << new_order;
         for (int k = 0; k < NUM_SLOTS; k++) begin
            free_address_ff[k] <= '0;
         end
      end else if (cmd.allocate) begin
         free_valid_ff <= free_valid_in;
         for (int k = 0; k < NUM_SLOTS; k++) begin
            free_address_ff[k] <= free_address_in[k];
         end
      end
   end

   // Request order register.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         want_ff <= want_in;
      end
   end

   // Response register, loaded once per allocation.
   always_ff @(posedge clock) begin
      if (cmd.allocate) begin
         rsp_granted_ff       <= alloc_found;
         rsp_block_address_ff <= alloc_found ? alloc_base : '0;
      end
   end

   assign rsp_granted       = rsp_granted_ff;
   assign rsp_block_address = rsp_block_address_ff;

   // No free block ever sits above the pool order.
   `BBA_ASSERT(a_no_slot_above_pool, (((free_valid_ff >> mem_order_ff) >> 1) == '0), "free block above pool order")
   // A refused allocation leaves the free slots untouched.
   `BBA_ASSERT(a_refuse_keeps_state, (cmd.allocate && !alloc_found && !csr_wr_en) |=> $stable(free_valid_ff), "refused request changed free slots")
   // A successful allocation is reported as granted.
   `BBA_ASSERT(a_found_is_granted, (cmd.allocate && alloc_found) |=> rsp_granted_ff, "found block not granted")

endmodule

// ===== hw/rtl/buddy_block_allocator.sv =====
// ----------------------------------------------------------------------------
// Buddy block allocator
// Allocate-only buddy allocator with one free slot per order.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Word
//   req_      in         request_size
//   rsp_      out        granted, block_address
//   csr_      in         mem_order write, no read-back
//
// Each word is captured first, which registers the order of its size, then
// goes through the priority search over the free slots and the split. A new
// word is taken in the cycle its predecessor's response is taken, not before.
// A stalled response holds off new words.
// Reset and any pool order write leave a single free block at address 0.
// ----------------------------------------------------------------------------
module buddy_block_allocator
   import bba_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [SIZE_W-1:0]  req_request_size,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_granted,
   output logic [ADDR_W-1:0]  rsp_block_address,
   input  logic               csr_wr_en,
   input  logic [ORDER_W-1:0] csr_wr_data
);

   bba_cmd_type cmd;

   // Controller.
   bba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // Datapath.
   bba_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_request_size  (req_request_size),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .rsp_granted       (rsp_granted),
      .rsp_block_address (rsp_block_address)
   );

endmodule
